/* src/utf8dcf_pkg.sv */
`default_nettype none

package utf8dcf_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned PEND_W = 2;

  // fold_mode codes; the unused code behaves as FOLD_STRIP
  localparam logic [MODE_W-1:0] FOLD_RAW   = 2'd0;
  localparam logic [MODE_W-1:0] FOLD_LOWER = 2'd1;
  localparam logic [MODE_W-1:0] FOLD_STRIP = 2'd2;

  // A decoded code point leaving the decoder
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] cp;
  } dec_result_t;

endpackage

`default_nettype wire

/* src/utf8_decode_case_fold_unit.sv */
// A result reaches m_axis from its last byte through the input register, then
// the result register; a stall on m_axis can hold it in either.
// Throughput: one byte per cycle; back pressure on the result side stalls input.
// Reset (rst, synchronous, active high) closes any open sequence, empties both
// registers and sets fold_mode to raw code points.
`default_nettype none

module utf8_decode_case_fold_unit (
  input  wire        clk,
  input  wire        rst,
  // configuration: fold_mode
  input  wire        cfg_we,
  input  wire  [1:0] cfg_wdata,
  // input items
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire        s_axis_tlast,   // end_of_text
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata   // [20:0] code_point, [23:21] zero
);
  import utf8dcf_pkg::*;

  // Configuration register
  logic [MODE_W-1:0] fold_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_mode <= FOLD_RAW;
    end else if (cfg_we) begin
      fold_mode <= cfg_wdata;
    end
  end

  // Input register: holds one byte until the decoder consumes it
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eot;

  // Result register
  logic              out_valid;
  logic [CP_W-1:0]   out_cp;

  logic              advance;
  dec_result_t       dec;
  logic [CP_W-1:0]   folded;

  // Decode the held byte whenever the result slot is free or draining this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eot  <= s_axis_tlast;
    end
  end

  utf8dcf_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item_byte  (in_byte),
    .item_eot   (in_eot),
    .result     (dec)
  );

  utf8dcf_fold u_fold (
    .fold_mode (fold_mode),
    .cp_in     (dec.cp),
    .cp_out    (folded)
  );

  // Load a result when one is produced; otherwise drop the slot once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dec.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.valid) begin
      out_cp <= folded;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cp};

  // An empty input register must always take a byte.
  assert property (@(posedge clk) disable iff (rst) !in_valid |-> s_axis_tready)
    else $error("input register empty but not ready");

  // A full input register behind a stalled result must hold off new bytes.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("byte accepted while pipeline stalled");

  // Every decoded code point reaches the result register.
  assert property (@(posedge clk) disable iff (rst)
    (advance && dec.valid) |=> m_axis_tvalid)
    else $error("decoded code point lost");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(out_cp)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* src/utf8dcf_decode.sv */
`default_nettype none

module utf8dcf_decode (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  input  wire  [utf8dcf_pkg::BYTE_W-1:0]   item_byte,
  input  wire                              item_eot,
  output utf8dcf_pkg::dec_result_t         result
);
  import utf8dcf_pkg::*;

  logic [PEND_W-1:0] bytes_pending;
  logic [PEND_W-1:0] bytes_pending_next;
  logic [CP_W-1:0]   partial_value;
  logic [CP_W-1:0]   partial_value_next;

  logic            is_cont;
  logic [CP_W-1:0] shifted;

  assign is_cont = (item_byte[7:6] == 2'b10);
  assign shifted = {partial_value[CP_W-7:0], item_byte[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    result.valid       = 1'b0;
    result.cp          = '0;
    if (bytes_pending != '0 && is_cont) begin
      // add six bits and count down
      bytes_pending_next = bytes_pending - 1'b1;
      partial_value_next = shifted;
      if (bytes_pending == 2'd1) begin
        result.valid       = 1'b1;
        result.cp          = shifted;
        partial_value_next = '0;
      end
    end else begin
      // no sequence open, or a broken one: drop it and take the byte as a lead
      bytes_pending_next = '0;
      partial_value_next = '0;
      priority if (item_byte[7] == 1'b0) begin
        result.valid = 1'b1;
        result.cp    = CP_W'(item_byte);
      end else if (item_byte[7:5] == 3'b110) begin
        partial_value_next = CP_W'(item_byte[4:0]);
        bytes_pending_next = 2'd1;
      end else if (item_byte[7:4] == 4'b1110) begin
        partial_value_next = CP_W'(item_byte[3:0]);
        bytes_pending_next = 2'd2;
      end else if (item_byte[7:3] == 5'b11110) begin
        partial_value_next = CP_W'(item_byte[2:0]);
        bytes_pending_next = 2'd3;
      end else begin
        // stray continuation or invalid lead: drop
        bytes_pending_next = '0;
      end
    end
    if (item_eot && bytes_pending_next != '0) begin
      bytes_pending_next = '0;
      partial_value_next = '0;
    end
    if (!item_valid) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_value <= '0;
    end else if (item_valid) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

`default_nettype wire

/* src/utf8dcf_fold.sv */
`default_nettype none

module utf8dcf_fold (
  input  wire  [utf8dcf_pkg::MODE_W-1:0] fold_mode,
  input  wire  [utf8dcf_pkg::CP_W-1:0]   cp_in,
  output logic [utf8dcf_pkg::CP_W-1:0]   cp_out
);
  import utf8dcf_pkg::*;

  logic            latin;
  logic [7:0]      lo;
  logic [7:0]      lowered;
  logic [7:0]      stripped;
  logic            do_lower;
  logic            do_strip;

  assign latin    = (cp_in[CP_W-1:8] == '0);
  assign lo       = cp_in[7:0];
  assign do_lower = (fold_mode != FOLD_RAW);
  assign do_strip = fold_mode[1];

  always_comb begin
    lowered = lo;
    if (do_lower && ((lo >= 8'h41 && lo <= 8'h5A) ||
                     (lo >= 8'hC0 && lo <= 8'hDE && lo != 8'hD7))) begin
      lowered = lo + 8'h20;
    end
  end

  always_comb begin
    stripped = lowered;
    if (do_strip) begin
      priority if (lowered >= 8'hE0 && lowered <= 8'hE5) stripped = 8'h61;
      else if (lowered == 8'hE7)                         stripped = 8'h63;
      else if (lowered >= 8'hE8 && lowered <= 8'hEB)     stripped = 8'h65;
      else if (lowered >= 8'hEC && lowered <= 8'hEF)     stripped = 8'h69;
      else if (lowered == 8'hF1)                         stripped = 8'h6E;
      else if (lowered >= 8'hF2 && lowered <= 8'hF6)     stripped = 8'h6F;
      else if (lowered >= 8'hF9 && lowered <= 8'hFC)     stripped = 8'h75;
      else if (lowered == 8'hFD || lowered == 8'hFF)     stripped = 8'h79;
      else                                               stripped = lowered;
    end
  end

  assign cp_out = latin ? CP_W'(stripped) : cp_in;

endmodule

`default_nettype wire
